// ----- sv/bgc_pkg.sv -----
package bgc_pkg;

    typedef struct packed {
        logic [7:0]      alpha;
        logic [2:0][7:0] ch;     // 0 red, 1 green, 2 blue
    } pix_t;

    localparam logic [1:0] CFG_GRAY     = 2'd0;
    localparam logic [1:0] CFG_BRIGHT   = 2'd1;
    localparam logic [1:0] CFG_CONTRAST = 2'd2;

    localparam logic [7:0]         PIX_MAX    = 8'd255;
    localparam logic signed [8:0]  UNITY      = 9'sd100;
    localparam logic signed [18:0] MID_OFFSET = 19'sd25500;

    // ceil(2^24/100) and ceil(2^25/200): exact floor division over the value ranges used
    localparam logic [17:0] RECIP_100 = 18'd167773;
    localparam int          SHIFT_100 = 24;
    localparam logic [17:0] RECIP_200 = 18'd167773;
    localparam int          SHIFT_200 = 25;

endpackage

// ----- sv/bgc_gray.sv -----
module bgc_gray
    import bgc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic gray_en,
    input  logic in_valid,
    output logic in_ready,
    input  pix_t in_pix,
    output logic out_valid,
    input  logic out_ready,
    output pix_t out_pix
);

    logic        valid_reg;
    pix_t        pix_reg;
    pix_t        pix_next;
    logic [12:0] sum;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sum = {5'd0, in_pix.ch[0]} * 13'd11
            + {5'd0, in_pix.ch[1]} * 13'd16
            + {5'd0, in_pix.ch[2]} * 13'd5;
        pix_next = in_pix;
        if (gray_en)
        begin
            pix_next.ch[0] = sum[12:5];
            pix_next.ch[1] = sum[12:5];
            pix_next.ch[2] = sum[12:5];
            pix_next.alpha = PIX_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

// ----- sv/bgc_bright.sv -----
module bgc_bright
    import bgc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] level,
    input  logic       in_valid,
    output logic       in_ready,
    input  pix_t       in_pix,
    output logic       out_valid,
    input  logic       out_ready,
    output pix_t       out_pix
);

    logic signed [8:0] factor;
    logic              factor_pos;
    logic [2:0][15:0]  prod_next;
    logic [2:0][15:0]  prod_reg;
    logic [7:0]        alpha_a_reg;
    logic              valid_a_reg;
    logic              ready_a;
    logic [2:0][33:0]  scaled;
    logic [2:0][9:0]   quot;
    pix_t              pix_next;
    pix_t              pix_reg;
    logic              valid_b_reg;

    // zero level gives factor 100, which leaves the channel unchanged
    assign factor     = $signed({level[7], level}) + UNITY;
    assign factor_pos = !factor[8] && (factor != 9'sd0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = factor_pos ? {8'd0, in_pix.ch[i]} * {8'd0, factor[7:0]} : 16'd0;
        end
    end

    assign ready_a  = !valid_b_reg || out_ready;
    assign in_ready = !valid_a_reg || ready_a;

    always_comb
    begin
        pix_next.alpha = alpha_a_reg;
        for (int i = 0; i < 3; i++)
        begin
            scaled[i] = {18'd0, prod_reg[i]} * {16'd0, RECIP_100};
            quot[i]   = scaled[i][SHIFT_100 +: 10];
            pix_next.ch[i] = (quot[i] > {2'd0, PIX_MAX}) ? PIX_MAX : quot[i][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_a)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg    <= prod_next;
            alpha_a_reg <= in_pix.alpha;
        end
        if (valid_a_reg && ready_a)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_pix   = pix_reg;

endmodule

// ----- sv/bgc_contrast.sv -----
module bgc_contrast
    import bgc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] level,
    input  logic       in_valid,
    output logic       in_ready,
    input  pix_t       in_pix,
    output logic       out_valid,
    input  logic       out_ready,
    output pix_t       out_pix
);

    logic signed [8:0]       factor;
    logic signed [18:0]      factor_x;
    logic [2:0][9:0]         ramp;
    logic signed [18:0]      num [3];
    logic [2:0][16:0]        num_next;
    logic [2:0][16:0]        num_reg;
    logic [7:0]              alpha_a_reg;
    logic                    valid_a_reg;
    logic                    ready_a;
    logic [2:0][34:0]        scaled;
    logic [2:0][9:0]         quot;
    pix_t                    pix_next;
    pix_t                    pix_reg;
    logic                    valid_b_reg;

    // zero level gives factor 100, and the ramp reduces to the identity
    assign factor   = $signed({level[7], level}) + UNITY;
    assign factor_x = 19'(factor);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ramp[i]     = {1'b0, in_pix.ch[i], 1'b0} - 10'd255;
            num[i]      = 19'($signed(ramp[i])) * factor_x + MID_OFFSET;
            num_next[i] = (num[i] <= 19'sd0) ? 17'd0 : num[i][16:0];
        end
    end

    assign ready_a  = !valid_b_reg || out_ready;
    assign in_ready = !valid_a_reg || ready_a;

    always_comb
    begin
        pix_next.alpha = alpha_a_reg;
        for (int i = 0; i < 3; i++)
        begin
            scaled[i] = {18'd0, num_reg[i]} * {17'd0, RECIP_200};
            quot[i]   = scaled[i][SHIFT_200 +: 10];
            pix_next.ch[i] = (quot[i] > {2'd0, PIX_MAX}) ? PIX_MAX : quot[i][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_a)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            num_reg     <= num_next;
            alpha_a_reg <= in_pix.alpha;
        end
        if (valid_a_reg && ready_a)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_pix   = pix_reg;

endmodule

// ----- sv/pixel_gray_brightness_contrast.sv -----
// Each accepted input beat passes through these registered stages in order
// (grayscale, brightness multiply, divide by 100, contrast multiply, divide by 200).
// Throughput: one pixel per cycle unless out_ready stalls; each stage holds one beat
// and advances when the stage after it is empty or taken.
// Reset (rst_n low, asynchronous) empties the pipeline and clears all three
// settings to zero, so pixels pass unchanged.
module pixel_gray_brightness_contrast
    import bgc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    input  logic [7:0] alpha_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [7:0] alpha_out
);

    logic       gray_en_reg;
    logic [7:0] bright_reg;
    logic [7:0] contrast_reg;

    pix_t in_pix;
    pix_t gray_pix;
    pix_t bright_pix;
    pix_t final_pix;
    logic gray_valid;
    logic gray_ready;
    logic bright_valid;
    logic bright_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_en_reg  <= 1'b0;
            bright_reg   <= 8'd0;
            contrast_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAY:     gray_en_reg  <= cfg_data[0];
                CFG_BRIGHT:   bright_reg   <= cfg_data;
                CFG_CONTRAST: contrast_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign in_pix.ch[0] = red_in;
    assign in_pix.ch[1] = green_in;
    assign in_pix.ch[2] = blue_in;
    assign in_pix.alpha = alpha_in;

    bgc_gray u_gray (
        .clk       (clk),
        .rst_n     (rst_n),
        .gray_en   (gray_en_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_pix    (in_pix),
        .out_valid (gray_valid),
        .out_ready (gray_ready),
        .out_pix   (gray_pix)
    );

    bgc_bright u_bright (
        .clk       (clk),
        .rst_n     (rst_n),
        .level     (bright_reg),
        .in_valid  (gray_valid),
        .in_ready  (gray_ready),
        .in_pix    (gray_pix),
        .out_valid (bright_valid),
        .out_ready (bright_ready),
        .out_pix   (bright_pix)
    );

    bgc_contrast u_contrast (
        .clk       (clk),
        .rst_n     (rst_n),
        .level     (contrast_reg),
        .in_valid  (bright_valid),
        .in_ready  (bright_ready),
        .in_pix    (bright_pix),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pix   (final_pix)
    );

    assign red_out   = final_pix.ch[0];
    assign green_out = final_pix.ch[1];
    assign blue_out  = final_pix.ch[2];
    assign alpha_out = final_pix.alpha;

endmodule

// ----- dv/pixel_gray_brightness_contrast_test.sv -----
`timescale 1ns / 1ps

module pixel_gray_brightness_contrast_test
    import bgc_pkg::*;
;

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // no register behind this index
    localparam int         DIR_ROWS   = 23;
    localparam int         PLAN_SIZE  = 8;
    localparam int         PHASES     = 12;
    localparam int         PHASE_PIXELS = 54;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic       gray;
        logic [7:0] bright;   // two's complement percent
        logic [7:0] contr;    // two's complement percent
    } setting_t;

    typedef struct packed {
        setting_t cfg;
        pix_t     pix;        // 32'hAABBGGRR
        logic     given;      // expected value typed in below
        pix_t     want;
    } dir_row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = CFG_GRAY;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] red_in    = 8'd0;
    logic [7:0] green_in  = 8'd0;
    logic [7:0] blue_in   = 8'd0;
    logic [7:0] alpha_in  = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    setting_t active = '0;
    pix_t     pending_pixels [$];
    int       mismatches  = 0;
    int       pixels_sent = 0;
    int       pixels_seen = 0;
    int       cycles      = 0;
    int       holds_asked = 0;
    int       holds_done  = 0;
    int       hold_left   = 0;
    int       stall_mode  = 0;
    int       pattern_left = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // pass-through right after reset
        '{'{1'b0, 8'd0, 8'd0}, 32'h4E38220C, 1'b1, 32'h4E38220C},
        '{'{1'b0, 8'd0, 8'd0}, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{'{1'b0, 8'd0, 8'd0}, 32'h00000000, 1'b1, 32'h00000000},
        // grayscale forces alpha opaque
        '{'{1'b1, 8'd0, 8'd0}, 32'h00FFFFFF, 1'b1, 32'hFFFFFFFF},
        '{'{1'b1, 8'd0, 8'd0}, 32'h00000000, 1'b1, 32'hFF000000},
        '{'{1'b1, 8'd0, 8'd0}, 32'h110000FF, 1'b0, 32'h0},
        '{'{1'b1, 8'd0, 8'd0}, 32'hA5C0FF10, 1'b0, 32'h0},
        // brightness at or below -100 blacks out the color channels (8'h80 is -128)
        '{'{1'b0, 8'h80, 8'd0}, 32'h093264C8, 1'b1, 32'h09000000},
        '{'{1'b0, -8'sd100, 8'd0}, 32'h03FFFFFF, 1'b1, 32'h03000000},
        // brightness at or above 100 saturates
        '{'{1'b0, 8'd127, 8'd0}, 32'h000001FF, 1'b1, 32'h000002FF},
        '{'{1'b0, 8'd100, 8'd0}, 32'hA5007F80, 1'b0, 32'h0},
        '{'{1'b0, 8'd100, 8'd0}, 32'h5A643219, 1'b0, 32'h0},
        // contrast of -100 flattens the ramp, below -100 inverts it
        '{'{1'b0, 8'd0, 8'h80}, 32'h008000FF, 1'b0, 32'h0},
        '{'{1'b0, 8'd0, 8'h80}, 32'h7F7F8081, 1'b0, 32'h0},
        '{'{1'b0, 8'd0, -8'sd100}, 32'h3C0080FF, 1'b1, 32'h3C7F7F7F},
        // contrast at or above 100 clamps both ends
        '{'{1'b0, 8'd0, 8'd127}, 32'h80FF00FF, 1'b1, 32'h80FF00FF},
        '{'{1'b0, 8'd0, 8'd127}, 32'h007F807F, 1'b0, 32'h0},
        '{'{1'b0, 8'd0, 8'd100}, 32'hC8408180, 1'b0, 32'h0},
        // brightness and contrast chained, with and without grayscale
        '{'{1'b1, 8'd50, -8'sd50}, 32'h12345678, 1'b0, 32'h0},
        '{'{1'b1, 8'h80, 8'd127}, 32'h77FFFFFF, 1'b1, 32'hFF000000},
        '{'{1'b1, 8'd127, 8'h80}, 32'h00808080, 1'b0, 32'h0},
        '{'{1'b0, -8'sd1, 8'd1}, 32'h01FE0102, 1'b0, 32'h0},
        '{'{1'b0, 8'd1, -8'sd1}, 32'hFE01FEFD, 1'b0, 32'h0}
    };

    setting_t phase_plan [PLAN_SIZE] = '{
        '{1'b0, 8'd0, 8'd0},
        '{1'b1, 8'd0, 8'd0},
        '{1'b0, 8'h80, 8'd0},
        '{1'b0, 8'd127, 8'd0},
        '{1'b0, 8'd0, 8'h80},
        '{1'b1, 8'd0, 8'd127},
        '{1'b0, 8'd100, -8'sd100},
        '{1'b1, -8'sd100, 8'd100}
    };

    pixel_gray_brightness_contrast dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pix_t adjust_pixel(input pix_t p);
        pix_t q;
        int   c [3];
        int   num;
        int   gray;
        int   i;
        q = p;
        for (i = 0; i < 3; i++)
            c[i] = int'(p.ch[i]);
        if (active.gray)
        begin
            gray = (11 * c[0] + 16 * c[1] + 5 * c[2]) >> 5;
            for (i = 0; i < 3; i++)
                c[i] = gray;
            q.alpha = PIX_MAX;
        end
        if (active.bright != 8'd0)
        begin
            for (i = 0; i < 3; i++)
            begin
                num = c[i] * (100 + int'($signed(active.bright)));
                c[i] = (num <= 0) ? 0 : ((num / 100 > 255) ? 255 : num / 100);
            end
        end
        if (active.contr != 8'd0)
        begin
            for (i = 0; i < 3; i++)
            begin
                num = (2 * c[i] - 255) * (100 + int'($signed(active.contr))) + 25500;
                c[i] = (num <= 0) ? 0 : ((num / 200 > 255) ? 255 : num / 200);
            end
        end
        for (i = 0; i < 3; i++)
            q.ch[i] = 8'(c[i]);
        return q;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h expected %0h (result %0d, cycle %0d)",
                 what, got, want, pixels_seen, cycles);
        mismatches++;
    endtask

    // Write all registers back to back; the unused index comes last so an
    // aliased decode would corrupt a live setting.
    task automatic load_settings(input setting_t s);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRAY;
        cfg_data  <= {7'($urandom), s.gray};   // upper bits must be ignored
        @(posedge clk);
        cfg_index <= CFG_BRIGHT;
        cfg_data  <= s.bright;
        @(posedge clk);
        cfg_index <= CFG_CONTRAST;
        cfg_data  <= s.contr;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        active = s;
    endtask

    task automatic send_pixel(input pix_t p, input logic given, input pix_t want);
        in_valid <= 1'b1;
        red_in   <= p.ch[0];
        green_in <= p.ch[1];
        blue_in  <= p.ch[2];
        alpha_in <= p.alpha;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_pixels.push_back(given ? want : adjust_pixel(p));
        pixels_sent++;
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        pix_t want;
        if (rst_n && out_valid && out_ready)
        begin
            pixels_seen++;
            if (pending_pixels.size() == 0)
                report_mismatch("beat with nothing pending",
                                {alpha_out, blue_out, green_out, red_out}, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (red_out !== want.ch[0])
                    report_mismatch("red_out", int'(red_out), int'(want.ch[0]));
                if (green_out !== want.ch[1])
                    report_mismatch("green_out", int'(green_out), int'(want.ch[1]));
                if (blue_out !== want.ch[2])
                    report_mismatch("blue_out", int'(blue_out), int'(want.ch[2]));
                if (alpha_out !== want.alpha)
                    report_mismatch("alpha_out", int'(alpha_out), int'(want.alpha));
            end
        end
    end

    // Receiver: a randomly chosen stall pattern drives out_ready; a requested
    // hold-off overrides it.
    always @(posedge clk)
    begin : drive_out_ready
        if (holds_done < holds_asked)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (pattern_left == 0)
        begin
            stall_mode   = $urandom_range(0, 3);
            pattern_left = $urandom_range(8, 64);
        end
        else
            pattern_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ~out_ready;
            endcase
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still pending",
                     cycles, pending_pixels.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        setting_t         s;
        logic [3:0][7:0]  lanes;
        int               r;
        int               ph;
        int               k;
        int               n;
        int               burst;
        int               gap;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].cfg != active)
            begin
                wait_for_idle();
                load_settings(dir_rows[r].cfg);
            end
            send_pixel(dir_rows[r].pix, dir_rows[r].given, dir_rows[r].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph < PLAN_SIZE)
                s = phase_plan[ph];
            else
            begin
                s.gray   = 1'($urandom);
                s.bright = 8'($urandom);
                s.contr  = 8'($urandom);
            end
            wait_for_idle();
            load_settings(s);
            if (ph == 5)
                holds_asked++;
            n = 0;
            while (n < PHASE_PIXELS)
            begin
                // the first burst of the hold-off phase keeps offering beats
                // until the pipeline backs up into the input
                burst = (ph == 5 && n == 0) ? 30 : $urandom_range(1, 20);
                if (burst > PHASE_PIXELS - n)
                    burst = PHASE_PIXELS - n;
                for (k = 0; k < burst; k++)
                begin
                    for (int lane = 0; lane < 4; lane++)
                    begin
                        case ($urandom_range(0, 9))
                            0:       lanes[lane] = 8'h00;
                            1:       lanes[lane] = 8'hFF;
                            default: lanes[lane] = 8'($urandom);
                        endcase
                    end
                    send_pixel(lanes, 1'b0, '0);
                    n++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        wait_for_idle();
        $display("%0d pixels sent, %0d results compared, over %0d setting phases",
                 pixels_sent, pixels_seen, PHASES);
        $display("covered pass-through, grayscale, and brightness/contrast at both range ends");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
